// File: rtl/core/rie_pkg.sv
package rie_pkg;

  localparam int POS_WIDTH   = 24;
  localparam int VALUE_WIDTH = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;
  localparam int MODE_W      = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ENCODE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_MARK   = 2'd0,
    MODE_EQUAL  = 2'd1,
    MODE_CONSEC = 2'd2,
    MODE_CUT    = 2'd3
  } mode_t;

  typedef struct packed {
    logic                          mark_bit;
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic                          last_item;
  } item_t;

  typedef struct packed {
    logic [POS_WIDTH-1:0] run_start;
    logic [POS_WIDTH-1:0] run_end;
    logic                 final_interval;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } res_pair_t;

endpackage

// File: rtl/core/rie_if.sv
interface rie_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mark_bit;
  logic signed [rie_pkg::VALUE_WIDTH-1:0] sample_value;
  logic                                   last_item;

  modport source (output valid, mark_bit, sample_value, last_item, input ready);
  modport sink   (input valid, mark_bit, sample_value, last_item, output ready);
endinterface

interface rie_out_if;
  logic                           valid;
  logic                           ready;
  logic [rie_pkg::POS_WIDTH-1:0]  run_start;
  logic [rie_pkg::POS_WIDTH-1:0]  run_end;
  logic                           final_interval;

  modport source (output valid, run_start, run_end, final_interval, input ready);
  modport sink   (input valid, run_start, run_end, final_interval, output ready);
endinterface

// File: rtl/core/rie_core.sv
module rie_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rie_pkg::mode_t                    mode,
  input  logic [rie_pkg::POS_WIDTH-1:0]     base,
  input  logic                              fire,
  input  rie_pkg::item_t                    item,
  output rie_pkg::res_pair_t                res
);

  localparam int PW = rie_pkg::POS_WIDTH;
  localparam int VW = rie_pkg::VALUE_WIDTH;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  logic          in_run_r, in_run_nxt;
  logic [PW-1:0] open_start_r, open_start_nxt;
  logic [VW-1:0] prior_value_r, prior_value_nxt;
  logic [PW-1:0] position_r, position_nxt;
  logic          first_pending_r, first_pending_nxt;

  logic [PW:0]   sum_p, sum_p1;
  logic [PW-1:0] p, p1;
  logic [VW-1:0] val;
  logic          cut;
  logic          a_v, b_v;
  rie_pkg::res_t a, b;

  always_comb begin
    sum_p  = {1'b0, base} + {1'b0, position_r};
    p      = sum_p[PW] ? POS_MAX : sum_p[PW-1:0];
    sum_p1 = {1'b0, p} + {{PW{1'b0}}, 1'b1};
    p1     = sum_p1[PW] ? POS_MAX : sum_p1[PW-1:0];
    val    = VW'(unsigned'(item.sample_value));
  end

  always_comb begin
    in_run_nxt      = in_run_r;
    open_start_nxt  = open_start_r;
    prior_value_nxt = prior_value_r;
    a_v = 1'b0;
    b_v = 1'b0;
    a   = '{run_start: open_start_r, run_end: p, final_interval: 1'b0};
    b   = '{run_start: open_start_r, run_end: p1, final_interval: 1'b1};
    cut = 1'b0;
    if (mode == rie_pkg::MODE_MARK) begin
      if (in_run_r) begin
        if (!item.mark_bit) begin
          a_v = 1'b1;
          a.final_interval = item.last_item;
          in_run_nxt = 1'b0;
        end
      end else if (item.mark_bit) begin
        open_start_nxt = p;
        in_run_nxt     = 1'b1;
      end
      b_v = item.last_item && in_run_nxt;
      b.run_start = open_start_nxt;
    end else begin
      if (first_pending_r) begin
        open_start_nxt = p;
      end else begin
        case (mode)
          rie_pkg::MODE_EQUAL:  cut = val != prior_value_r;
          rie_pkg::MODE_CONSEC: cut = val != VW'(prior_value_r + VW'(1));
          default:              cut = item.mark_bit;
        endcase
        if (cut) begin
          a_v = 1'b1;
          open_start_nxt = p;
        end
      end
      prior_value_nxt = val;
      b_v = item.last_item;
      b.run_start = open_start_nxt;
    end
  end

  always_comb begin
    res.v0 = a_v || b_v;
    res.v1 = a_v && b_v;
    res.r0 = a_v ? a : b;
    res.r1 = b;
    position_nxt      = (position_r == POS_MAX) ? POS_MAX : position_r + PW'(1);
    first_pending_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r        <= 1'b0;
      open_start_r    <= '0;
      prior_value_r   <= '0;
      position_r      <= '0;
      first_pending_r <= 1'b1;
    end else if (fire) begin
      if (item.last_item) begin
        in_run_r        <= 1'b0;
        open_start_r    <= '0;
        prior_value_r   <= '0;
        position_r      <= '0;
        first_pending_r <= 1'b1;
      end else begin
        in_run_r        <= in_run_nxt;
        open_start_r    <= open_start_nxt;
        prior_value_r   <= prior_value_nxt;
        position_r      <= position_nxt;
        first_pending_r <= first_pending_nxt;
      end
    end
  end

endmodule

// File: rtl/core/rie_queue.sv
module rie_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rie_pkg::res_pair_t wr,
  output logic               room2,
  output logic               rd_valid,
  input  logic               rd_ready,
  output rie_pkg::res_t      rd_data
);

  localparam int PTRW = rie_pkg::QPTR_W;
  localparam int CNTW = rie_pkg::QCNT_W;

  rie_pkg::res_t mem_r [rie_pkg::QUEUE_DEPTH];
  logic [PTRW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            w0, w1, pop;

  always_comb begin
    room2    = cnt_r <= CNTW'(rie_pkg::QUEUE_DEPTH - 2);
    rd_valid = cnt_r != '0;
    rd_data  = mem_r[rp_r];
    w0       = push && wr.v0;
    w1       = push && wr.v1;
    pop      = rd_valid && rd_ready;
    wp_nxt   = wp_r + PTRW'(w0) + PTRW'(w1);
    rp_nxt   = rp_r + PTRW'(pop);
    cnt_nxt  = cnt_r + CNTW'(w0) + CNTW'(w1) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (w0) mem_r[wp_r] <= wr.r0;
    if (w1) mem_r[wp_r + PTRW'(1)] <= wr.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/run_interval_encoder.sv
// A taken input word is registered, then its results enter the result queue.
// Throughput: one word per cycle while the queue has room for two results;
//   the single output port drains the queue, one result per cycle while ready.
// Reset: synchronous, active low; clears sequence state, registers and queue,
//   mode 0 and offset 0 afterwards.
module run_interval_encoder (
  input  logic                               clk,
  input  logic                               rst_n,
  rie_in_if.sink                             in_ch,
  rie_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [rie_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rie_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rie_pkg::mode_t                 mode_r;
  logic [rie_pkg::POS_WIDTH-1:0]  base_r;
  logic                           item_v_r;
  rie_pkg::item_t                 item_r;
  logic                           fire, room2;
  rie_pkg::res_pair_t             res;
  rie_pkg::res_t                  head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rie_pkg::MODE_MARK;
      base_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rie_pkg::REG_ENCODE_MODE: mode_r <= rie_pkg::mode_t'(cfg_data[rie_pkg::MODE_W-1:0]);
        rie_pkg::REG_BASE_OFFSET: base_r <= cfg_data[rie_pkg::POS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign fire        = item_v_r && room2;
  assign in_ch.ready = !item_v_r || room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= '{mark_bit: in_ch.mark_bit, sample_value: in_ch.sample_value,
                  last_item: in_ch.last_item};
    end
  end

  rie_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .mode  (mode_r),
    .base  (base_r),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  rie_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fire),
    .wr       (res),
    .room2    (room2),
    .rd_valid (out_ch.valid),
    .rd_ready (out_ch.ready),
    .rd_data  (head)
  );

  assign out_ch.run_start      = head.run_start;
  assign out_ch.run_end        = head.run_end;
  assign out_ch.final_interval = head.final_interval;

endmodule

// File: rtl/core/rie_checker.sv
module rie_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rie_pkg::POS_WIDTH-1:0]     run_start,
  input logic [rie_pkg::POS_WIDTH-1:0]     run_end,
  input logic                              final_interval
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("outputs not idle after reset");

  a_final_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && final_interval |-> run_end != '0)
    else $error("closing word has zero end bound");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(run_start) && $stable(run_end)
      && $stable(final_interval))
    else $error("result word changed while stalled");

endmodule

bind run_interval_encoder rie_checker u_rie_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .run_start      (out_ch.run_start),
  .run_end        (out_ch.run_end),
  .final_interval (out_ch.final_interval)
);

// File: dv/rie_interval_check.sv
`timescale 1ns / 100ps

module rie_interval_check
  import rie_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  rie_in_if                     in_ch,
  rie_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    checked
);

  typedef logic [POS_WIDTH-1:0] pos_t;

  mode_t                  mode;
  pos_t                   offset;
  logic                   in_run;
  logic                   first_pending;
  pos_t                   open_start;
  pos_t                   position;
  logic [VALUE_WIDTH-1:0] prior_value;

  res_t due_intervals[$];
  res_t expected;
  res_t got;
  int   fail_count;
  int   checked_count;

  function automatic pos_t clamp_pos(logic [POS_WIDTH:0] v);
    return v[POS_WIDTH] ? {POS_WIDTH{1'b1}} : v[POS_WIDTH-1:0];
  endfunction

  function automatic void restart_sequence();
    in_run        = 1'b0;
    open_start    = '0;
    prior_value   = '0;
    position      = '0;
    first_pending = 1'b1;
  endfunction

  function automatic void encode_word(logic mark, logic [VALUE_WIDTH-1:0] val, logic last);
    pos_t p;
    pos_t p1;
    logic cut;
    p  = clamp_pos({1'b0, offset} + {1'b0, position});
    p1 = clamp_pos({1'b0, p} + 1'b1);
    if (mode == MODE_MARK) begin
      if (in_run) begin
        if (!mark) begin
          due_intervals.push_back('{open_start, p, last});
          in_run = 1'b0;
        end
      end else if (mark) begin
        open_start = p;
        in_run     = 1'b1;
      end
      if (last && in_run) due_intervals.push_back('{open_start, p1, 1'b1});
    end else begin
      if (first_pending) begin
        open_start = p;
      end else begin
        case (mode)
          MODE_EQUAL:  cut = val != prior_value;
          MODE_CONSEC: cut = val != VALUE_WIDTH'(prior_value + 1'b1);
          default:     cut = mark;
        endcase
        if (cut) begin
          due_intervals.push_back('{open_start, p, 1'b0});
          open_start = p;
        end
      end
      prior_value = val;
      if (last) due_intervals.push_back('{open_start, p1, 1'b1});
    end
    first_pending = 1'b0;
    position      = clamp_pos({1'b0, position} + 1'b1);
    if (last) restart_sequence();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode   = MODE_MARK;
      offset = '0;
      restart_sequence();
      due_intervals.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        encode_word(in_ch.mark_bit, in_ch.sample_value, in_ch.last_item);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.run_start, out_ch.run_end, out_ch.final_interval};
        if (due_intervals.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: start=%h end=%h final=%b",
                     got.run_start, got.run_end, got.final_interval);
        end else begin
          expected = due_intervals.pop_front();
          checked_count++;
          if (got.run_start !== expected.run_start || got.run_end !== expected.run_end ||
              got.final_interval !== expected.final_interval) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected start=%h end=%h final=%b, got start=%h end=%h final=%b",
                       expected.run_start, expected.run_end, expected.final_interval,
                       got.run_start, got.run_end, got.final_interval);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_ENCODE_MODE) mode = mode_t'(cfg_data[MODE_W-1:0]);
        else offset = cfg_data[POS_WIDTH-1:0];
      end
    end
    mismatches  <= fail_count;
    outstanding <= due_intervals.size();
    checked     <= checked_count;
  end

endmodule

// File: dv/run_interval_encoder_test.sv
`timescale 1ns / 100ps

module run_interval_encoder_test;
  import rie_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int checked;

  int   sent;
  int   sequences;
  int   settings;
  logic steady;

  logic                          mark_now;
  logic signed [VALUE_WIDTH-1:0] value_now;

  rie_in_if  in_ch ();
  rie_out_if out_ch ();

  run_interval_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rie_interval_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always #1 clk = ~clk;

  task automatic send_word(logic mark, logic signed [VALUE_WIDTH-1:0] val, logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mark_bit     <= mark;
    in_ch.sample_value <= val;
    in_ch.last_item    <= last;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (last) sequences++;
  endtask

  // drain: all due words back, then allow for words still in the pipe
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(mode_t m, logic [POS_WIDTH-1:0] off);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENCODE_MODE;
    cfg_data  <= CFG_DATA_W'(m);
    @(posedge clk);
    cfg_index <= REG_BASE_OFFSET;
    cfg_data  <= CFG_DATA_W'(off);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send_sequence(int len, logic close);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 2) == 0) mark_now = ~mark_now;
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3, 4, 5: value_now = value_now + 1;
        6: begin
          case ($urandom_range(0, 3))
            0:       value_now = 32'sh7fffffff;
            1:       value_now = 32'sh80000000;
            2:       value_now = '0;
            default: value_now = '1;
          endcase
        end
        default: value_now = $urandom;
      endcase
      send_word(mark_now, value_now, close && i == len - 1);
    end
  endtask

  initial begin
    int gap;
    int taken;
    logic held;
    taken = 0;
    held  = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 18);
      // one long back-pressure stretch to fill the block
      if (!held && taken == 150) begin
        gap  = 400;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int phase;
    int target;
    int len;
    int guard;
    logic [POS_WIDTH-1:0] off;
    sent      = 0;
    sequences = 0;
    settings  = 0;
    steady    = 1'b0;
    mark_now  = 1'b0;
    value_now = '0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_ENCODE_MODE;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mark_bit     <= 1'b0;
    in_ch.sample_value <= '0;
    in_ch.last_item    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mark runs: single-word run, empty close, open run closed by a clear mark
    program_regs(MODE_MARK, '0);
    send_word(1'b1, 32'sh7fffffff, 1'b1);
    send_word(1'b0, 32'sh80000000, 1'b1);
    send_word(1'b1, 0, 1'b0);
    send_word(1'b1, 0, 1'b0);
    send_word(1'b0, 0, 1'b0);
    send_word(1'b1, 0, 1'b0);
    send_word(1'b0, 0, 1'b1);
    send_word(1'b1, -1, 1'b0);
    send_word(1'b1, -1, 1'b1);
    // cut segments, mark on the opening word ignored
    settle();
    program_regs(MODE_CUT, 24'd5);
    send_word(1'b1, 1, 1'b0);
    send_word(1'b0, 2, 1'b0);
    send_word(1'b1, 3, 1'b0);
    send_word(1'b1, 4, 1'b1);
    // consecutive values wrapping from the top to the bottom
    settle();
    program_regs(MODE_CONSEC, '0);
    send_word(1'b0, 32'sh7ffffffe, 1'b0);
    send_word(1'b0, 32'sh7fffffff, 1'b0);
    send_word(1'b0, 32'sh80000000, 1'b0);
    send_word(1'b0, 5, 1'b1);
    // equal values with the position saturating
    settle();
    program_regs(MODE_EQUAL, 24'hfffffd);
    send_word(1'b0, -1, 1'b0);
    send_word(1'b0, -1, 1'b0);
    send_word(1'b0, 7, 1'b0);
    send_word(1'b0, 7, 1'b1);
    // mode switched with a sequence open
    settle();
    program_regs(MODE_EQUAL, '0);
    send_word(1'b0, 3, 1'b0);
    send_word(1'b0, 3, 1'b0);
    settle();
    program_regs(MODE_CUT, '0);
    send_word(1'b1, 3, 1'b1);

    phase = 0;
    while (sent < 1750) begin
      settle();
      case ($urandom_range(0, 5))
        0:       off = '0;
        1:       off = '1;
        2:       off = {POS_WIDTH{1'b1}} - POS_WIDTH'($urandom_range(0, 40));
        default: off = POS_WIDTH'($urandom);
      endcase
      program_regs(mode_t'(phase % 4), off);
      steady = ($urandom_range(0, 3) == 0);
      target = sent + $urandom_range(40, 120);
      while (sent < target) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        send_sequence(len, $urandom_range(0, 9) != 0);
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (outstanding != 0 && guard < 50000);
    repeat (8) @(posedge clk);

    $display("Drove %0d words in %0d closed sequences over %0d register settings, all modes.",
             sent, sequences, settings);
    $display("%0d intervals compared, base offsets from zero up to the saturating top.",
             checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rie_pkg.sv
rtl/core/rie_if.sv
rtl/core/rie_core.sv
rtl/core/rie_queue.sv
rtl/core/run_interval_encoder.sv
rtl/core/rie_checker.sv
dv/rie_interval_check.sv
dv/run_interval_encoder_test.sv
